// File: rtl/hjd_pkg.sv
// ----------------------------------------------------------------------------
// hjd_pkg: shared types and constants for the headset jack detect controller
// Item structs, phase and register codes, reset values and slot ring sizing.
// ----------------------------------------------------------------------------
package hjd_pkg;

    // hook report ring
    localparam int BUTTON_SLOTS = 4;
    localparam int TIMER_BITS   = 8;
    localparam int SLOT_W       = (BUTTON_SLOTS > 1) ? $clog2(BUTTON_SLOTS) : 1;
    localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;

    // counter limits
    localparam logic [7:0] ELAPSED_MAX = 8'd255;
    localparam logic [3:0] CHANGES_MAX = 4'd15;

    // register reset values
    localparam logic [7:0] DEBOUNCE_RST     = 8'd35;
    localparam logic [3:0] RETRY_RST        = 4'd10;
    localparam logic [7:0] CODEC_WAIT_RST   = 8'd20;
    localparam logic [7:0] REPORT_DELAY_RST = 8'd30;

    // plug kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PHONE = 2'd1;
    localparam logic [1:0] KIND_SET   = 2'd2;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_RETRY        = 2'd1,
        CFG_CODEC_WAIT   = 2'd2,
        CFG_REPORT_DELAY = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_WAIT     = 3'b010,
        PH_DEBOUNCE = 3'b100
    } phase_t;

    typedef struct packed {
        logic jack_level;
        logic hook_level;
        logic jack_event;
        logic hook_event;
        logic codec_suspended;
    } in_item_t;

    typedef struct packed {
        logic [1:0] plug_kind;
        logic       button_down;
        logic       mic_bias_on;
        logic       detect_busy;
        logic       plug_report;
        logic       button_report;
        logic       bounce_overflow;
    } out_item_t;

    // top level to ring
    typedef struct packed {
        logic step;
        logic hook_event;
        logic hook_level;
        logic available;
    } ring_ctrl_t;

    // ring to top level
    typedef struct packed {
        logic report;
        logic key;
    } ring_report_t;

endpackage

// File: rtl/hjd_button_ring.sv
// ----------------------------------------------------------------------------
// hjd_button_ring: ring of delayed hook button reports
// Each hook event takes the next slot; armed slots count down one per item and
// report their key on expiry if available. Expiry precedes the new hook event.
// ----------------------------------------------------------------------------
module hjd_button_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hjd_pkg::ring_ctrl_t   ctrl,
    input  logic [7:0]            report_delay,
    output hjd_pkg::ring_report_t rep
);
    import hjd_pkg::*;

    logic [SLOT_W-1:0]     ring_reg, ring_next;
    logic [BUTTON_SLOTS-1:0] busy_reg, busy_next;
    logic [BUTTON_SLOTS-1:0] key_reg, key_next;
    logic [TIMER_BITS-1:0] timer_reg [BUTTON_SLOTS];
    logic [TIMER_BITS-1:0] timer_next [BUTTON_SLOTS];
    logic [15:0]           delay_wide;
    logic [TIMER_BITS-1:0] arm_value;

    // arm value saturates to the timer range
    assign delay_wide = 16'(report_delay);
    assign arm_value  = (delay_wide > 16'(TIMER_MAX)) ? TIMER_BITS'(TIMER_MAX)
                                                      : TIMER_BITS'(delay_wide);

    always_comb
    begin
        ring_next  = ring_reg;
        busy_next  = busy_reg;
        key_next   = key_reg;
        timer_next = timer_reg;
        rep        = '0;

        // expiry, slot order, last one wins
        for (int i = 0; i < BUTTON_SLOTS; i++)
        begin
            if (busy_reg[i])
            begin
                if (timer_reg[i] <= TIMER_BITS'(1))
                begin
                    busy_next[i]  = 1'b0;
                    timer_next[i] = '0;
                    if (ctrl.available)
                    begin
                        rep.report = 1'b1;
                        rep.key    = key_reg[i];
                    end
                end
                else
                begin
                    timer_next[i] = timer_reg[i] - TIMER_BITS'(1);
                end
            end
        end

        // new hook event
        if (ctrl.hook_event)
        begin
            ring_next = (ring_reg == SLOT_W'(BUTTON_SLOTS - 1)) ? '0
                                                                : ring_reg + SLOT_W'(1);
            if (ctrl.available)
            begin
                for (int i = 0; i < BUTTON_SLOTS; i++)
                begin
                    if (ring_reg == SLOT_W'(i))
                    begin
                        key_next[i] = ctrl.hook_level;
                        if (!busy_next[i])
                        begin
                            busy_next[i]  = 1'b1;
                            timer_next[i] = arm_value;
                        end
                    end
                end
            end
            else
            begin
                rep.report = 1'b1;
                rep.key    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg  <= '0;
            busy_reg  <= '0;
            key_reg   <= '0;
            for (int i = 0; i < BUTTON_SLOTS; i++)
            begin
                timer_reg[i] <= '0;
            end
        end
        else if (ctrl.step)
        begin
            ring_reg  <= ring_next;
            busy_reg  <= busy_next;
            key_reg   <= key_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// File: rtl/headset_jack_detect_controller.sv
// ----------------------------------------------------------------------------
// headset_jack_detect_controller: jack detection and hook button reporting
// Plug detection sequencer with debounce, plus a ring of delayed key reports.
// ----------------------------------------------------------------------------
// Usage:
//   One input item per 10 ms tick on in_item (valid/ready). Each accepted item
//   gives exactly one result item on out_item (valid/ready).
//   The result is in the output register the cycle after the item is accepted.
//   Throughput: one item per cycle unless the receiver stalls; the whole tick
//   update is one pass of logic from in_item to the state and output registers.
//   in_ready is high while the output register is empty or is being taken,
//   so a new item enters in the same cycle the previous result leaves.
//   If the receiver stalls, the result is held and in_ready drops; no item is
//   lost or repeated, and state only moves on an accepted item.
//   Configuration: cfg_we/cfg_index/cfg_data write one register per cycle,
//   with no wait; the user writes only while the block is idle (not enforced).
//   Reset (rst_n low, asynchronous): phase idle, nothing plugged, bias off,
//   buttons masked, ring empty, registers back to their default values.
// ----------------------------------------------------------------------------
module headset_jack_detect_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hjd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output hjd_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import hjd_pkg::*;

    // configuration registers
    logic [7:0] debounce_reg;
    logic [3:0] retry_reg;
    logic [7:0] codec_wait_reg;
    logic [7:0] report_delay_reg;

    // detection state
    phase_t     phase_reg, phase_next;
    logic [7:0] elapsed_reg, elapsed_next;
    logic [3:0] changes_reg, changes_next;
    logic       held_jack_reg, held_jack_next;
    logic [1:0] start_kind_reg, start_kind_next;
    logic [1:0] kind_reg, kind_next;
    logic       button_reg, button_next;
    logic       bias_reg, bias_next;
    logic       mask_reg, mask_next;
    logic       pend_reg, pend_next;

    // output stage
    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;

    logic         step;
    logic         leave_wait;
    logic         plug_report;
    logic         overflow;
    ring_ctrl_t   ring_ctrl;
    ring_report_t ring_rep;

    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RST;
            retry_reg        <= RETRY_RST;
            codec_wait_reg   <= CODEC_WAIT_RST;
            report_delay_reg <= REPORT_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE:     debounce_reg     <= cfg_data;
                CFG_RETRY:        retry_reg        <= cfg_data[3:0];
                CFG_CODEC_WAIT:   codec_wait_reg   <= cfg_data;
                CFG_REPORT_DELAY: report_delay_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------- detection
    always_comb
    begin
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        changes_next    = changes_reg;
        held_jack_next  = held_jack_reg;
        start_kind_next = start_kind_reg;
        kind_next       = kind_reg;
        bias_next       = bias_reg;
        mask_next       = mask_reg;
        pend_next       = pend_reg;
        plug_report     = 1'b0;
        overflow        = 1'b0;
        leave_wait      = 1'b0;

        if (phase_reg == PH_DEBOUNCE)
        begin
            if (in_item.jack_event)
                pend_next = 1'b1;
            if (elapsed_reg < ELAPSED_MAX)
                elapsed_next = elapsed_reg + 8'd1;
            // any level change restarts the stable count
            if (in_item.jack_level != held_jack_reg)
            begin
                elapsed_next   = '0;
                held_jack_next = in_item.jack_level;
                if (changes_reg < CHANGES_MAX)
                    changes_next = changes_reg + 4'd1;
            end
            if (elapsed_next >= debounce_reg || changes_next >= retry_reg)
            begin
                overflow = (changes_next >= retry_reg);
                if (held_jack_next)
                    kind_next = KIND_NONE;
                else if (start_kind_reg == KIND_NONE)
                    kind_next = in_item.hook_level ? KIND_PHONE : KIND_SET;
                else
                    kind_next = start_kind_reg;
                if (kind_next != KIND_SET)
                    bias_next = 1'b0;
                else
                    mask_next = 1'b0;
                plug_report = 1'b1;
                phase_next  = PH_IDLE;
            end
        end
        else
        begin
            if (phase_reg == PH_WAIT)
            begin
                if (in_item.jack_event)
                    pend_next = 1'b1;
            end
            else if (in_item.jack_event || pend_reg)
            begin
                pend_next       = 1'b0;
                start_kind_next = kind_reg;
                elapsed_next    = '0;
                changes_next    = '0;
                phase_next      = PH_WAIT;
            end
            // codec wait, evaluated on the starting tick too
            if (phase_next == PH_WAIT)
            begin
                leave_wait = !in_item.codec_suspended;
                if (!leave_wait)
                begin
                    if (elapsed_next < ELAPSED_MAX)
                        elapsed_next = elapsed_next + 8'd1;
                    leave_wait = (elapsed_next >= codec_wait_reg);
                end
                if (leave_wait)
                begin
                    mask_next      = 1'b1;
                    bias_next      = 1'b1;
                    held_jack_next = in_item.jack_level;
                    phase_next     = PH_DEBOUNCE;
                end
            end
        end
    end

    // --------------------------------------------------------- button ring
    // availability uses the state as detection leaves it this tick
    always_comb
    begin
        ring_ctrl.step       = step;
        ring_ctrl.hook_event = in_item.hook_event;
        ring_ctrl.hook_level = in_item.hook_level;
        ring_ctrl.available  = !mask_next && !in_item.jack_level && (kind_next == KIND_SET);
    end

    hjd_button_ring u_ring (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ring_ctrl),
        .report_delay (report_delay_reg),
        .rep          (ring_rep)
    );

    assign button_next = ring_rep.report ? ring_rep.key : button_reg;

    // ------------------------------------------------------------ result
    always_comb
    begin
        out_item_next.plug_kind       = kind_next;
        out_item_next.button_down     = button_next;
        out_item_next.mic_bias_on     = bias_next;
        out_item_next.detect_busy     = (phase_next != PH_IDLE);
        out_item_next.plug_report     = plug_report;
        out_item_next.button_report   = ring_rep.report;
        out_item_next.bounce_overflow = overflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            elapsed_reg    <= '0;
            changes_reg    <= '0;
            held_jack_reg  <= 1'b1;
            start_kind_reg <= KIND_NONE;
            kind_reg       <= KIND_NONE;
            button_reg     <= 1'b0;
            bias_reg       <= 1'b0;
            mask_reg       <= 1'b1;
            pend_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            changes_reg    <= changes_next;
            held_jack_reg  <= held_jack_next;
            start_kind_reg <= start_kind_next;
            kind_reg       <= kind_next;
            button_reg     <= button_next;
            bias_reg       <= bias_next;
            mask_reg       <= mask_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_item_reg <= out_item_next;
    end

`ifndef NO_ASSERTIONS
    // a finished detection never leaves the sequence running
    a_report_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.plug_report |-> !out_item_reg.detect_busy)
        else $error("plug report while detection still busy");

    // overflow only on the item that ends detection
    a_overflow_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.bounce_overflow |-> out_item_reg.plug_report)
        else $error("bounce overflow without plug report");

    // once idle, bias is only kept for a headset
    a_bias_idle: assert property (@(posedge clk) disable iff (!rst_n)
        bias_reg && (phase_reg == PH_IDLE) |-> (kind_reg == KIND_SET))
        else $error("mic bias left on without a headset");

    // buttons are only unmasked for a headset
    a_mask_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !mask_reg |-> (kind_reg == KIND_SET))
        else $error("buttons unmasked without a headset");

    // state moves only on an accepted item
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(kind_reg) && $stable(button_reg))
        else $error("detection state changed without an item");
`endif

endmodule
